// ----- rtl/rrle_pkg.sv -----
// ----------------------------------------------------------------------------
// rrle_pkg
// shared constants and types of the row run-length encoder
// ----------------------------------------------------------------------------
package rrle_pkg;

    localparam int PIX_W         = 16;
    localparam int CNT_W         = 13;
    localparam int MAX_WIDTH     = 4096;
    localparam int LITERAL_LIMIT = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int LIT_IDX_W     = $clog2(LITERAL_LIMIT);

    localparam logic [CNT_W-1:0] ROW_WIDTH_RESET = CNT_W'(MAX_WIDTH);

    localparam logic KIND_LITERAL = 1'b0;
    localparam logic KIND_RUN     = 1'b1;

    localparam logic [2:0] ADDR_ROW_WIDTH = 3'd0;

    // one closed run
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] value;
        logic [CNT_W-1:0] count;
    } run_cmd_t;

    // runs closed by one item: a run closed by a new value, then the row-end run
    typedef struct packed {
        run_cmd_t first;
        run_cmd_t row_run;
    } run_entry_t;

endpackage

// ----- rtl/rrle_front.sv -----
// ----------------------------------------------------------------------------
// rrle_front
// takes pixels, tracks the open run and the column, and queues closed runs
// ----------------------------------------------------------------------------
module rrle_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [rrle_pkg::PIX_W-1:0] pixel,
    input  logic [rrle_pkg::CNT_W-1:0] row_width,
    input  logic                       q_full,
    output logic                       q_push,
    output rrle_pkg::run_entry_t       q_entry
);
    import rrle_pkg::*;

    logic [PIX_W-1:0] held_value_reg, held_value_next;
    logic [CNT_W-1:0] run_length_reg, run_length_next;
    logic [CNT_W-1:0] column_reg, column_next;

    logic             accept;
    logic [CNT_W-1:0] width_eff;
    logic [CNT_W:0]   column_inc;
    logic             ends_row;
    logic             close_first;
    logic             open_new;
    logic [PIX_W-1:0] cur_value;
    logic [CNT_W-1:0] cur_length;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        if (row_width == '0)
            width_eff = CNT_W'(1);
        else if (row_width > CNT_W'(MAX_WIDTH))
            width_eff = CNT_W'(MAX_WIDTH);
        else
            width_eff = row_width;
    end

    assign column_inc  = {1'b0, column_reg} + (CNT_W+1)'(1);
    assign ends_row    = column_inc >= {1'b0, width_eff};
    assign close_first = (run_length_reg != '0) && (pixel != held_value_reg);
    assign open_new    = close_first || (run_length_reg == '0);
    assign cur_value   = open_new ? pixel : held_value_reg;
    assign cur_length  = open_new ? CNT_W'(1) : run_length_reg + CNT_W'(1);

    always_comb
    begin
        q_entry.first.valid   = close_first;
        q_entry.first.value   = held_value_reg;
        q_entry.first.count   = run_length_reg;
        q_entry.row_run.valid = ends_row;
        q_entry.row_run.value = cur_value;
        q_entry.row_run.count = cur_length;
        q_push                = accept && (close_first || ends_row);
    end

    always_comb
    begin
        held_value_next = held_value_reg;
        run_length_next = run_length_reg;
        column_next     = column_reg;
        if (accept)
        begin
            held_value_next = cur_value;
            if (ends_row)
            begin
                run_length_next = '0;
                column_next     = '0;
            end
            else
            begin
                run_length_next = cur_length;
                column_next     = column_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_value_reg <= '0;
            run_length_reg <= '0;
            column_reg     <= '0;
        end
        else
        begin
            held_value_reg <= held_value_next;
            run_length_reg <= run_length_next;
            column_reg     <= column_next;
        end
    end

endmodule

// ----- rtl/rrle_queue.sv -----
// ----------------------------------------------------------------------------
// rrle_queue
// short queue of closed runs between front and back
// ----------------------------------------------------------------------------
module rrle_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  rrle_pkg::run_entry_t wr_entry,
    output logic                 q_full,
    input  logic                 rd_en,
    output logic                 q_empty,
    output rrle_pkg::run_entry_t rd_entry
);
    import rrle_pkg::*;

    run_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign q_full   = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_empty  = count_reg == '0;
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            if (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_rd)
        begin
            if (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (do_wr && !do_rd)
            count_next = count_reg + QCNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/rrle_back.sv -----
// ----------------------------------------------------------------------------
// rrle_back
// expands runs to literal/run tokens, one item per cycle while pop keeps up
// ----------------------------------------------------------------------------
module rrle_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  rrle_pkg::run_entry_t       q_entry,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic                       kind,
    output logic [rrle_pkg::PIX_W-1:0] value,
    output logic [rrle_pkg::CNT_W-1:0] run_count,
    output logic                       row_end,
    output logic                       last
);
    import rrle_pkg::*;

    logic                 phase_reg, phase_next;
    logic [LIT_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg;
    logic [PIX_W-1:0]     value_reg;
    logic [CNT_W-1:0]     run_count_reg;
    logic                 row_end_reg;
    logic                 last_reg;

    logic             slot_free;
    logic             step;
    logic             sel_row;
    run_cmd_t         cur;
    logic             is_run;
    logic             cmd_done;
    logic             entry_done;

    assign slot_free = !out_valid_reg || pop;
    assign step      = slot_free && !q_empty;
    assign sel_row   = phase_reg || !q_entry.first.valid;
    assign cur       = sel_row ? q_entry.row_run : q_entry.first;
    assign is_run    = cur.count > CNT_W'(LITERAL_LIMIT);
    assign cmd_done  = is_run || ((CNT_W'(idx_reg) + CNT_W'(1)) == cur.count);
    assign entry_done = cmd_done && (sel_row || !q_entry.row_run.valid);
    assign q_pop     = step && entry_done;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (step)
        begin
            if (!cmd_done)
                idx_next = idx_reg + LIT_IDX_W'(1);
            else if (entry_done)
            begin
                phase_next = 1'b0;
                idx_next   = '0;
            end
            else
            begin
                phase_next = 1'b1;
                idx_next   = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register, payload only
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            kind_reg      <= is_run ? KIND_RUN : KIND_LITERAL;
            value_reg     <= cur.value;
            run_count_reg <= is_run ? cur.count : CNT_W'(1);
            row_end_reg   <= sel_row && cmd_done;
            last_reg      <= entry_done;
        end
    end

    assign empty     = !out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign run_count = run_count_reg;
    assign row_end   = row_end_reg;
    assign last      = last_reg;

endmodule

// ----- rtl/row_run_length_encoder.sv -----
// ----------------------------------------------------------------------------
// row_run_length_encoder
// run-length codes each row of a raster pixel stream into literal and run items
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while full is low; one result item per cycle from the expander while pop keeps up
// path: a closed run is written to the run queue, then registered in the expander output
// one pixel can give up to six items, queued as one entry in the four-entry run queue
// reset: no run open, column zero, row_width 4096, output and queue empty
// ----------------------------------------------------------------------------
module row_run_length_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       push,
    output logic                       full,
    input  logic [rrle_pkg::PIX_W-1:0] pixel,
    output logic                       empty,
    input  logic                       pop,
    output logic                       kind,
    output logic [rrle_pkg::PIX_W-1:0] value,
    output logic [rrle_pkg::CNT_W-1:0] run_count,
    output logic                       row_end,
    output logic                       last
);
    import rrle_pkg::*;

    logic [CNT_W-1:0] row_width_reg, row_width_next;
    logic             cfg_wr;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    run_entry_t       wr_entry;
    run_entry_t       rd_entry;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        row_width_next = row_width_reg;
        if (cfg_wr && (paddr[2] == ADDR_ROW_WIDTH[2]))
            row_width_next = pwdata[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_width_reg <= ROW_WIDTH_RESET;
        else
            row_width_reg <= row_width_next;
    end

    always_comb
    begin
        if (paddr[2] == ADDR_ROW_WIDTH[2])
            prdata = {(32-CNT_W)'(0), row_width_reg};
        else
            prdata = '0;
    end

    rrle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .row_width (row_width_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (wr_entry)
    );

    rrle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (wr_entry),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .q_empty  (q_empty),
        .rd_entry (rd_entry)
    );

    rrle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (rd_entry),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .value     (value),
        .run_count (run_count),
        .row_end   (row_end),
        .last      (last)
    );

endmodule
